// ===== sv/lvg_pkg.sv =====
// ----------------------------------------------------------------------------
// lvg_pkg
// Shared types and constants for the gcd / lcm core: operand and result
// widths, the queued item, the item classes and the back-end states.
// ----------------------------------------------------------------------------
package lvg_pkg;

    localparam int OPND_W      = 32;
    localparam int LCM_W       = 64;
    localparam int DEF_WIDTH   = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_ONE_ZERO,
        KIND_BOTH_ZERO
    } t_kind;

    typedef struct packed {
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        t_kind             kind;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL
    } t_state;

endpackage

// ===== sv/lcm_via_euclid_gcd_core.sv =====
// ----------------------------------------------------------------------------
// lcm_via_euclid_gcd_core
// Greatest common divisor and least common multiple of two unsigned operands.
// ----------------------------------------------------------------------------
// An operand pair is taken when start is high and busy is low; busy is high
// only while the two-entry input queue is full. Each pair gives one result,
// shown for one cycle with o_strobe high, in input order; the receiver cannot
// stall it. A pair with a zero operand is finished in the idle state and
// its result is registered for the strobe. Any other pair runs through the
// binary gcd reduction (one step per cycle in the back end, ending with a
// step that finds the two values equal), the bit-serial divider for
// first / gcd (one quotient bit per cycle, WIDTH bits) and the final
// multiply. Items are worked on one at a time by the back end; the queue
// lets new pairs arrive meanwhile.
// ----------------------------------------------------------------------------
module lcm_via_euclid_gcd_core #(
    parameter int WIDTH       = lvg_pkg::DEF_WIDTH,
    parameter int QUEUE_DEPTH = lvg_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lvg_pkg::OPND_W-1:0]  i_first_value,
    input  logic [lvg_pkg::OPND_W-1:0]  i_second_value,
    output logic                        o_strobe,
    output logic [lvg_pkg::OPND_W-1:0]  o_gcd_value,
    output logic [lvg_pkg::LCM_W-1:0]   o_lcm_value,
    output logic                        o_zero_error
);

    logic               w_push;
    logic               w_pop;
    lvg_pkg::t_item     w_in_item;
    lvg_pkg::t_item     w_head_item;
    lvg_pkg::t_q_status w_q_status;

    assign busy = w_q_status.full;

    lvg_front #(
        .WIDTH (WIDTH)
    ) u_front (
        .start          (start),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_q_status     (w_q_status),
        .o_push         (w_push),
        .o_item         (w_in_item)
    );

    lvg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_in_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    lvg_back #(
        .WIDTH (WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_head_item),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_gcd_value  (o_gcd_value),
        .o_lcm_value  (o_lcm_value),
        .o_zero_error (o_zero_error)
    );

endmodule

// ===== sv/lvg_front.sv =====
// ----------------------------------------------------------------------------
// lvg_front
// Accepts operand pairs, masks them to the operand width and sorts them into
// normal pairs and pairs with a zero operand before they enter the queue.
// ----------------------------------------------------------------------------
module lvg_front #(
    parameter int WIDTH = lvg_pkg::DEF_WIDTH
) (
    input  logic                        start,
    input  logic [lvg_pkg::OPND_W-1:0]  i_first_value,
    input  logic [lvg_pkg::OPND_W-1:0]  i_second_value,
    input  lvg_pkg::t_q_status          i_q_status,
    output logic                        o_push,
    output lvg_pkg::t_item              o_item
);

    localparam logic [lvg_pkg::OPND_W-1:0] MASK =
        lvg_pkg::OPND_W'((64'd1 << WIDTH) - 64'd1);

    logic [lvg_pkg::OPND_W-1:0] w_a;
    logic [lvg_pkg::OPND_W-1:0] w_b;

    assign w_a    = i_first_value & MASK;
    assign w_b    = i_second_value & MASK;
    assign o_push = start && !i_q_status.full;

    always_comb begin
        o_item.a = w_a;
        o_item.b = w_b;
        priority if (w_a == '0 && w_b == '0) begin
            o_item.kind = lvg_pkg::KIND_BOTH_ZERO;
        end else if (w_a == '0 || w_b == '0) begin
            o_item.kind = lvg_pkg::KIND_ONE_ZERO;
        end else begin
            o_item.kind = lvg_pkg::KIND_NORMAL;
        end
    end

endmodule

// ===== sv/lvg_queue.sv =====
// ----------------------------------------------------------------------------
// lvg_queue
// Short first-in first-out queue of classified items between the front end
// and the arithmetic back end.
// ----------------------------------------------------------------------------
module lvg_queue #(
    parameter int DEPTH = lvg_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lvg_pkg::t_item      i_item,
    input  logic                i_pop,
    output lvg_pkg::t_item      o_item,
    output lvg_pkg::t_q_status  o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lvg_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_item         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/lvg_back.sv =====
// ----------------------------------------------------------------------------
// lvg_back
// Arithmetic back end: binary gcd one step per cycle, a restoring divider
// for first / gcd one bit per cycle, then one multiply by the second operand.
// ----------------------------------------------------------------------------
module lvg_back #(
    parameter int WIDTH = lvg_pkg::DEF_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lvg_pkg::t_item              i_item,
    input  lvg_pkg::t_q_status          i_q_status,
    output logic                        o_pop,
    output logic                        o_strobe,
    output logic [lvg_pkg::OPND_W-1:0]  o_gcd_value,
    output logic [lvg_pkg::LCM_W-1:0]   o_lcm_value,
    output logic                        o_zero_error
);

    localparam int CNT_W = $clog2(WIDTH);

    lvg_pkg::t_state r_state, n_state;
    logic [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0] r_b, n_b;
    logic [WIDTH-1:0] r_u, n_u;
    logic [WIDTH-1:0] r_v, n_v;
    logic [CNT_W-1:0] r_k, n_k;
    logic [WIDTH-1:0] r_g, n_g;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_strobe, n_strobe;
    logic [lvg_pkg::OPND_W-1:0] r_gcd_out, n_gcd_out;
    logic [lvg_pkg::LCM_W-1:0]  r_lcm_out, n_lcm_out;
    logic             r_err, n_err;

    logic [WIDTH:0]     w_trial;
    logic [WIDTH:0]     w_trial_sub;
    logic [WIDTH-1:0]   w_u_minus_v;
    logic [WIDTH-1:0]   w_v_minus_u;
    logic [2*WIDTH-1:0] w_prod;

    assign w_trial     = {r_rem, r_quo[WIDTH-1]};
    assign w_trial_sub = w_trial - {1'b0, r_g};
    assign w_u_minus_v = r_u - r_v;
    assign w_v_minus_u = r_v - r_u;
    assign w_prod      = r_quo * r_b;

    assign o_strobe     = r_strobe;
    assign o_gcd_value  = r_gcd_out;
    assign o_lcm_value  = r_lcm_out;
    assign o_zero_error = r_err;

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_u       = r_u;
        n_v       = r_v;
        n_k       = r_k;
        n_g       = r_g;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_strobe  = 1'b0;
        n_gcd_out = r_gcd_out;
        n_lcm_out = r_lcm_out;
        n_err     = r_err;
        o_pop     = 1'b0;
        unique case (r_state)
            lvg_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    n_a   = i_item.a[WIDTH-1:0];
                    n_b   = i_item.b[WIDTH-1:0];
                    n_u   = i_item.a[WIDTH-1:0];
                    n_v   = i_item.b[WIDTH-1:0];
                    n_k   = '0;
                    if (i_item.kind == lvg_pkg::KIND_NORMAL) begin
                        n_state = lvg_pkg::ST_GCD;
                    end else begin
                        n_strobe  = 1'b1;
                        n_gcd_out = i_item.a | i_item.b;
                        n_lcm_out = '0;
                        n_err     = (i_item.kind == lvg_pkg::KIND_BOTH_ZERO);
                    end
                end
            end
            lvg_pkg::ST_GCD: begin
                priority if (r_u == r_v) begin
                    n_g     = WIDTH'(r_u << r_k);
                    n_rem   = '0;
                    n_quo   = r_a;
                    n_cnt   = '0;
                    n_state = lvg_pkg::ST_DIV;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + CNT_W'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u > r_v) begin
                    n_u = w_u_minus_v >> 1;
                end else begin
                    n_v = w_v_minus_u >> 1;
                end
            end
            lvg_pkg::ST_DIV: begin
                if (!w_trial_sub[WIDTH]) begin
                    n_rem = w_trial_sub[WIDTH-1:0];
                    n_quo = {r_quo[WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[WIDTH-1:0];
                    n_quo = {r_quo[WIDTH-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    n_state = lvg_pkg::ST_MUL;
                end
            end
            lvg_pkg::ST_MUL: begin
                n_strobe  = 1'b1;
                n_gcd_out = lvg_pkg::OPND_W'(r_g);
                n_lcm_out = lvg_pkg::LCM_W'(w_prod);
                n_err     = 1'b0;
                n_state   = lvg_pkg::ST_IDLE;
            end
            default: begin
                n_state = lvg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lvg_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_u       <= n_u;
        r_v       <= n_v;
        r_k       <= n_k;
        r_g       <= n_g;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_gcd_out <= n_gcd_out;
        r_lcm_out <= n_lcm_out;
        r_err     <= n_err;
    end

endmodule

// ===== sv/lvg_checker.sv =====
// ----------------------------------------------------------------------------
// lvg_checker
// Port-level checks on the gcd / lcm core results, bound to the top level.
// ----------------------------------------------------------------------------
module lvg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic [lvg_pkg::OPND_W-1:0]  o_gcd_value,
    input logic [lvg_pkg::LCM_W-1:0]   o_lcm_value,
    input logic                        o_zero_error
);

    logic w_unused;
    assign w_unused = start ^ busy;

    a_no_strobe_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_strobe
    ) else $error("result strobe right after reset");

    a_error_gives_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_zero_error) |-> (o_gcd_value == '0 && o_lcm_value == '0)
    ) else $error("zero error with nonzero result");

    a_gcd_nonzero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_zero_error) |-> (o_gcd_value != '0)
    ) else $error("zero gcd without error flag");

    a_lcm_not_below_gcd: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_lcm_value != '0) |->
            (o_lcm_value >= lvg_pkg::LCM_W'(o_gcd_value))
    ) else $error("lcm below gcd");

endmodule

bind lcm_via_euclid_gcd_core lvg_checker u_lvg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_gcd_value  (o_gcd_value),
    .o_lcm_value  (o_lcm_value),
    .o_zero_error (o_zero_error)
);
